// File: src/assert_macros.svh
// Assertion macros used by the feature normalizer control module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define WSFN_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define WSFN_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check that an antecedent implies a consequent in the following cycle
`define WSFN_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/wsfn_pkg.sv
// Types and constants of the weather sensor feature normalizer
`timescale 1ns / 1ps
`default_nettype none
package wsfn_pkg;

	localparam int NUM_W = 20;
	localparam int MAG_W = 15;
	localparam int RES_W = 16;
	localparam int RSHIFT = 16;

	localparam int P_W = 17;
	localparam int T_W = 15;
	localparam int H_W = 14;

	localparam int P_MIN = 98090;
	localparam int P_SPAN = 6260;
	localparam int T_MIN = -540;
	localparam int T_SPAN = 4620;
	localparam int H_MIN = 1500;
	localparam int H_SPAN = 8500;
	localparam int DEW5_MIN = -6550;
	localparam int DEW5_SPAN = 19550;
	localparam int DEW5_OFS = -10000;
	localparam int DP_MIN = -960;
	localparam int DP_SPAN = 1620;
	localparam int DT_MIN = -2220;
	localparam int DT_SPAN = 4090;
	localparam int DH_MIN = -3700;
	localparam int DH_SPAN = 10200;

	localparam logic signed [T_W-1:0] HYGRO_LOW = -15'sd5000;
	localparam logic signed [T_W-1:0] HYGRO_HIGH = 15'sd10000;

	localparam logic [P_W-1:0] LAST_P_RST = 17'd101300;
	localparam logic signed [T_W-1:0] LAST_T_RST = 15'sd2000;
	localparam logic [H_W-1:0] LAST_H_RST = 14'd5000;

	typedef enum logic [1:0] {
		SAT_ZERO,
		SAT_ONE,
		SAT_CALC
	} wsfn_sat_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_out;
	} wsfn_adv_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] pres;
		logic signed [NUM_W-1:0] temp;
		logic signed [NUM_W-1:0] hum;
		logic signed [NUM_W-1:0] dew;
		logic signed [NUM_W-1:0] dpres;
		logic signed [NUM_W-1:0] dtemp;
		logic signed [NUM_W-1:0] dhum;
		logic signed [NUM_W-1:0] ppres;
		logic signed [NUM_W-1:0] ptemp;
		logic signed [NUM_W-1:0] phum;
	} wsfn_feat_t;

endpackage
`default_nettype wire

// File: src/weather_sensor_feature_normalizer.sv
// Top level of the weather sensor feature normalizer
//
//  channel   signals                          payload
//  sample    sample_valid / sample_ready      pressure, baro/hygro temperature, humidity
//  feature   feature_valid / feature_ready    ten normalized features, Q1.OUT_FRAC_BITS
//
//  One request per cycle while feature_ready does not hold a result; a request passes the stages below.
//  Stages: input register, reciprocal multiply register, result register.
//  Reset clears all valid bits and restores the history to its seed values.
//  A stalled result holds the result register; stages behind it keep filling.
`timescale 1ns / 1ps
`default_nettype none
module weather_sensor_feature_normalizer #(
	parameter int OUT_FRAC_BITS = 15
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic [wsfn_pkg::P_W-1:0]            pressure,
	input  logic signed [wsfn_pkg::T_W-1:0]     baro_temperature,
	input  logic signed [wsfn_pkg::T_W-1:0]     hygro_temperature,
	input  logic [wsfn_pkg::H_W-1:0]            humidity,
	output logic                                feature_valid,
	input  logic                                feature_ready,
	output logic [wsfn_pkg::RES_W-1:0]          norm_pressure,
	output logic [wsfn_pkg::RES_W-1:0]          norm_temperature,
	output logic [wsfn_pkg::RES_W-1:0]          norm_humidity,
	output logic [wsfn_pkg::RES_W-1:0]          norm_dew_point,
	output logic [wsfn_pkg::RES_W-1:0]          norm_pressure_change,
	output logic [wsfn_pkg::RES_W-1:0]          norm_temperature_change,
	output logic [wsfn_pkg::RES_W-1:0]          norm_humidity_change,
	output logic [wsfn_pkg::RES_W-1:0]          norm_prev_pressure,
	output logic [wsfn_pkg::RES_W-1:0]          norm_prev_temperature,
	output logic [wsfn_pkg::RES_W-1:0]          norm_prev_humidity
);
	import wsfn_pkg::*;

	wsfn_adv_t             adv;
	wsfn_feat_t            feat;
	logic [P_W-1:0]        pressure_s1;
	logic signed [T_W-1:0] baro_s1;
	logic signed [T_W-1:0] hygro_s1;
	logic [H_W-1:0]        humidity_s1;

	wsfn_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.feature_valid (feature_valid),
		.feature_ready (feature_ready),
		.adv           (adv)
	);

	always_ff @(posedge clk) begin
		if (adv.load_s1) begin
			pressure_s1 <= pressure;
			baro_s1 <= baro_temperature;
			hygro_s1 <= hygro_temperature;
			humidity_s1 <= humidity;
		end
	end

	wsfn_features u_features (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv),
		.pressure          (pressure_s1),
		.baro_temperature  (baro_s1),
		.hygro_temperature (hygro_s1),
		.humidity          (humidity_s1),
		.feat              (feat)
	);

	wsfn_norm_lane #(.FRAC_BITS(OUT_FRAC_BITS), .SPAN(P_SPAN)) u_pres (
		.clk (clk), .adv (adv), .num (feat.pres), .res (norm_pressure)
	);
	wsfn_norm_lane #(.FRAC_BITS(OUT_FRAC_BITS), .SPAN(T_SPAN)) u_temp (
		.clk (clk), .adv (adv), .num (feat.temp), .res (norm_temperature)
	);
	wsfn_norm_lane #(.FRAC_BITS(OUT_FRAC_BITS), .SPAN(H_SPAN)) u_hum (
		.clk (clk), .adv (adv), .num (feat.hum), .res (norm_humidity)
	);
	wsfn_norm_lane #(.FRAC_BITS(OUT_FRAC_BITS), .SPAN(DEW5_SPAN)) u_dew (
		.clk (clk), .adv (adv), .num (feat.dew), .res (norm_dew_point)
	);
	wsfn_norm_lane #(.FRAC_BITS(OUT_FRAC_BITS), .SPAN(DP_SPAN)) u_dpres (
		.clk (clk), .adv (adv), .num (feat.dpres), .res (norm_pressure_change)
	);
	wsfn_norm_lane #(.FRAC_BITS(OUT_FRAC_BITS), .SPAN(DT_SPAN)) u_dtemp (
		.clk (clk), .adv (adv), .num (feat.dtemp), .res (norm_temperature_change)
	);
	wsfn_norm_lane #(.FRAC_BITS(OUT_FRAC_BITS), .SPAN(DH_SPAN)) u_dhum (
		.clk (clk), .adv (adv), .num (feat.dhum), .res (norm_humidity_change)
	);
	wsfn_norm_lane #(.FRAC_BITS(OUT_FRAC_BITS), .SPAN(P_SPAN)) u_ppres (
		.clk (clk), .adv (adv), .num (feat.ppres), .res (norm_prev_pressure)
	);
	wsfn_norm_lane #(.FRAC_BITS(OUT_FRAC_BITS), .SPAN(T_SPAN)) u_ptemp (
		.clk (clk), .adv (adv), .num (feat.ptemp), .res (norm_prev_temperature)
	);
	wsfn_norm_lane #(.FRAC_BITS(OUT_FRAC_BITS), .SPAN(H_SPAN)) u_phum (
		.clk (clk), .adv (adv), .num (feat.phum), .res (norm_prev_humidity)
	);
endmodule
`default_nettype wire

// File: src/wsfn_ctrl.sv
// Valid tracking and stall control of the three register stages
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module wsfn_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	output logic                feature_valid,
	input  logic                feature_ready,
	output wsfn_pkg::wsfn_adv_t adv
);
	import wsfn_pkg::*;

	logic vld_s1;
	logic vld_s2;
	logic vld_q;
	logic all_full;

	always_comb begin
		adv.load_out = vld_s2 && (!vld_q || feature_ready);
		adv.load_s2 = vld_s1 && (!vld_s2 || adv.load_out);
		sample_ready = !vld_s1 || adv.load_s2;
		adv.load_s1 = sample_valid && sample_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			if (adv.load_s1) begin
				vld_s1 <= 1'b1;
			end else if (adv.load_s2) begin
				vld_s1 <= 1'b0;
			end
			if (adv.load_s2) begin
				vld_s2 <= 1'b1;
			end else if (adv.load_out) begin
				vld_s2 <= 1'b0;
			end
			if (adv.load_out) begin
				vld_q <= 1'b1;
			end else if (feature_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	assign feature_valid = vld_q;
	assign all_full = vld_s1 && vld_s2 && vld_q;

	`WSFN_ASSERT_IMP(a_s2_load_src, adv.load_s2, vld_s1, "stage 2 loaded from empty stage 1")
	`WSFN_ASSERT_IMP(a_full_blocks, all_full && !feature_ready, !sample_ready, "request taken when full")
	`WSFN_ASSERT_NXT(a_s1_drains, vld_s1 && !vld_s2, vld_s2, "stage 1 stuck before empty stage 2")
	`WSFN_ASSERT_IMP(a_out_source, $rose(vld_q), $past(vld_s2), "result without stage 2 data")
endmodule
`default_nettype wire

// File: src/wsfn_features.sv
// Working temperature, dew point, deltas and sample history
`timescale 1ns / 1ps
`default_nettype none
module wsfn_features (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wsfn_pkg::wsfn_adv_t                 adv,
	input  logic [wsfn_pkg::P_W-1:0]            pressure,
	input  logic signed [wsfn_pkg::T_W-1:0]     baro_temperature,
	input  logic signed [wsfn_pkg::T_W-1:0]     hygro_temperature,
	input  logic [wsfn_pkg::H_W-1:0]            humidity,
	output wsfn_pkg::wsfn_feat_t                feat
);
	import wsfn_pkg::*;

	logic                    seeded_q;
	logic [P_W-1:0]          last_p_q;
	logic signed [T_W-1:0]   last_t_q;
	logic [H_W-1:0]          last_h_q;

	logic signed [T_W:0]     tsum;
	logic signed [T_W-1:0]   temp;
	logic [P_W-1:0]          prev_p;
	logic signed [T_W-1:0]   prev_t;
	logic [H_W-1:0]          prev_h;
	logic signed [NUM_W-1:0] p_x;
	logic signed [NUM_W-1:0] t_x;
	logic signed [NUM_W-1:0] h_x;
	logic signed [NUM_W-1:0] lp_x;
	logic signed [NUM_W-1:0] lt_x;
	logic signed [NUM_W-1:0] lh_x;

	always_comb begin
		tsum = (T_W+1)'(baro_temperature) + (T_W+1)'(hygro_temperature);
		if (hygro_temperature > HYGRO_LOW && hygro_temperature < HYGRO_HIGH) begin
			temp = T_W'(tsum >>> 1);
		end else begin
			temp = baro_temperature;
		end
		prev_p = seeded_q ? last_p_q : pressure;
		prev_t = seeded_q ? last_t_q : temp;
		prev_h = seeded_q ? last_h_q : humidity;

		p_x = NUM_W'(pressure);
		t_x = NUM_W'(temp);
		h_x = NUM_W'(humidity);
		lp_x = NUM_W'(prev_p);
		lt_x = NUM_W'(prev_t);
		lh_x = NUM_W'(prev_h);

		feat.pres = p_x - NUM_W'(P_MIN);
		feat.temp = t_x - NUM_W'(T_MIN);
		feat.hum = h_x - NUM_W'(H_MIN);
		feat.dew = (t_x <<< 2) + t_x + NUM_W'(DEW5_OFS) + h_x - NUM_W'(DEW5_MIN);
		feat.dpres = p_x - lp_x - NUM_W'(DP_MIN);
		feat.dtemp = t_x - lt_x - NUM_W'(DT_MIN);
		feat.dhum = h_x - lh_x - NUM_W'(DH_MIN);
		feat.ppres = lp_x - NUM_W'(P_MIN);
		feat.ptemp = lt_x - NUM_W'(T_MIN);
		feat.phum = lh_x - NUM_W'(H_MIN);
	end

	// advance history as the request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			last_p_q <= LAST_P_RST;
			last_t_q <= LAST_T_RST;
			last_h_q <= LAST_H_RST;
		end else if (adv.load_s2) begin
			seeded_q <= 1'b1;
			last_p_q <= pressure;
			last_t_q <= temp;
			last_h_q <= humidity;
		end
	end
endmodule
`default_nettype wire

// File: src/wsfn_norm_lane.sv
// One min-max normalizer lane: clamp, reciprocal multiply, rounding fix
`timescale 1ns / 1ps
`default_nettype none
module wsfn_norm_lane #(
	parameter int FRAC_BITS = 15,
	parameter int SPAN = 1620
) (
	input  logic                                clk,
	input  wsfn_pkg::wsfn_adv_t                 adv,
	input  logic signed [wsfn_pkg::NUM_W-1:0]   num,
	output logic [wsfn_pkg::RES_W-1:0]          res
);
	import wsfn_pkg::*;

	localparam int RW = FRAC_BITS + 6;
	localparam int PW = MAG_W + RW;
	localparam int CW = FRAC_BITS + 18;
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << (FRAC_BITS + RSHIFT)) / SPAN);
	localparam logic signed [NUM_W-1:0] SPAN_N = NUM_W'(SPAN);
	localparam logic [PW:0] HALF = (PW+1)'(1) << (RSHIFT - 1);
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [CW-1:0] SPAN_C = CW'(SPAN);
	localparam logic [CW-1:0] DIV_C = CW'(2 * SPAN);

	wsfn_sat_t            sat_c;
	logic [MAG_W-1:0]     mag_c;
	logic [PW:0]          prod_c;
	logic [FRAC_BITS:0]   q0_c;
	wsfn_sat_t            sat_s2;
	logic [MAG_W-1:0]     mag_s2;
	logic [FRAC_BITS:0]   q0_s2;
	logic [CW-1:0]        lhs;
	logic [CW-1:0]        rhs;
	logic [FRAC_BITS:0]   q_c;
	logic [FRAC_BITS+16:0] q_ext;
	logic [RES_W-1:0]     res_q;

	always_comb begin
		if (num <= 0) begin
			sat_c = SAT_ZERO;
		end else if (num >= SPAN_N) begin
			sat_c = SAT_ONE;
		end else begin
			sat_c = SAT_CALC;
		end
		mag_c = num[MAG_W-1:0];
		prod_c = (PW+1)'(mag_c) * (PW+1)'(RECIP) + HALF;
		q0_c = prod_c[RSHIFT +: FRAC_BITS+1];
	end

	always_ff @(posedge clk) begin
		if (adv.load_s2) begin
			sat_s2 <= sat_c;
			mag_s2 <= mag_c;
			q0_s2 <= q0_c;
		end
	end

	// estimate is exact or one low; bump it when the next step still fits
	always_comb begin
		rhs = (CW'(mag_s2) << (FRAC_BITS + 1)) + SPAN_C;
		lhs = (CW'(q0_s2) + CW'(1)) * DIV_C;
		case (sat_s2)
			SAT_ZERO: q_c = '0;
			SAT_ONE:  q_c = ONE;
			SAT_CALC: q_c = q0_s2 + (FRAC_BITS+1)'(lhs <= rhs);
			default:  q_c = '0;
		endcase
		q_ext = (FRAC_BITS+17)'(q_c);
	end

	always_ff @(posedge clk) begin
		if (adv.load_out) begin
			res_q <= q_ext[RES_W-1:0];
		end
	end

	assign res = res_q;
endmodule
`default_nettype wire
